/* sv/bfm_pkg.sv */
// Shared types, constants and codes for the Bloom filter membership block.
`default_nettype none

package bfm_pkg;

    // Field widths
    localparam int KEY_W        = 64;
    localparam int ACTION_W     = 2;
    localparam int COUNT_W      = 32;
    localparam int NUM_BITS_W   = 17;
    localparam int NUM_HASHES_W = 5;
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 32;

    // Default sizing of the bit store and of the probe count
    localparam int MAX_BITS_DEFAULT   = 65536;
    localparam int MAX_HASHES_DEFAULT = 16;

    // Register reset values
    localparam logic [NUM_BITS_W-1:0]   NUM_BITS_RESET   = 17'd65536;
    localparam logic [NUM_HASHES_W-1:0] NUM_HASHES_RESET = 5'd7;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_BITS   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_HASHES = 8'd1;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    // Mixer constants
    localparam logic [31:0] MIX_MUL1    = 32'h85eb_ca6b;
    localparam logic [31:0] MIX_MUL2    = 32'hc2b2_ae35;
    localparam int          MIX_SHIFT_A = 16;
    localparam int          MIX_SHIFT_B = 13;

    // Bit store rows
    localparam int ROW_BITS  = 64;
    localparam int ROW_BIT_W = 6;

    // Remainder unit
    localparam int DIV_BITS_PER_CYCLE = 4;
    localparam int DIV_STEPS          = KEY_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [KEY_W-1:0]    key;
    } bfm_cmd_t;

    typedef struct packed {
        logic               might_contain;
        logic [COUNT_W-1:0] element_count;
    } bfm_result_t;

    typedef enum logic [2:0] {
        HOP_NONE,
        HOP_LOAD,
        HOP_MUL_LO,
        HOP_MUL_HI,
        HOP_MUL_SUM,
        HOP_MIX13
    } hash_op_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_LOAD,
        ST_MUL1_LO,
        ST_MUL1_HI,
        ST_MUL1_SUM,
        ST_MIX13,
        ST_MUL2_LO,
        ST_MUL2_HI,
        ST_MUL2_SUM,
        ST_MIX16,
        ST_DIV_WAIT,
        ST_READ,
        ST_ACCESS,
        ST_WIPE,
        ST_FINISH
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     latch;
        hash_op_t hop;
        logic     mul_sel;
        logic     div_start;
        logic     mem_read;
        logic     access;
        logic     sweep;
        logic     cnt_inc;
        logic     cnt_clr;
        logic     probe_next;
    } bfm_ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                no_probe;
        logic                last_probe;
        logic                miss;
        logic                div_busy;
        logic                sweep_last;
    } bfm_sts_t;

endpackage

`default_nettype wire

/* sv/bfm_divider.sv */
// Multi-cycle remainder unit: 64-bit dividend modulo a narrow divisor.
`default_nettype none

module bfm_divider #(
    parameter int DIV_W = 17
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [bfm_pkg::KEY_W-1:0] dividend,
    input  wire logic [DIV_W-1:0]         divisor,
    output logic                          busy,
    output logic [DIV_W-1:0]              remainder
);

    logic                            busy_reg, busy_next;
    logic [bfm_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [bfm_pkg::KEY_W-1:0]       shift_reg, shift_next;
    logic [DIV_W-1:0]                rem_reg, rem_next;
    logic [DIV_W-1:0]                dsr_reg, dsr_next;

    // Restoring remainder, a few dividend bits per cycle
    always_comb
    begin
        logic [DIV_W:0]            trial;
        logic [DIV_W-1:0]          r;
        logic [bfm_pkg::KEY_W-1:0] sh;
        r  = rem_reg;
        sh = shift_reg;
        for (int k = 0; k < bfm_pkg::DIV_BITS_PER_CYCLE; k++)
        begin
            trial = {r, sh[bfm_pkg::KEY_W-1]};
            sh    = {sh[bfm_pkg::KEY_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                trial = trial - {1'b0, dsr_reg};
            end
            r = trial[DIV_W-1:0];
        end

        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = dividend;
            rem_next   = '0;
            dsr_next   = divisor;
        end
        else if (busy_reg)
        begin
            shift_next = sh;
            rem_next   = r;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == bfm_pkg::DIV_CNT_W'(bfm_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        dsr_reg   <= dsr_next;
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* sv/bfm_datapath.sv */
// Datapath: config registers, probe hash, bit store, element count and result.
`default_nettype none

module bfm_datapath #(
    parameter int MAX_BITS   = bfm_pkg::MAX_BITS_DEFAULT,
    parameter int MAX_HASHES = bfm_pkg::MAX_HASHES_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire bfm_pkg::bfm_cmd_t              cmd,
    input  wire logic                           cfg_we,
    input  wire logic [bfm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bfm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire bfm_pkg::bfm_ctl_t              ctl,
    output bfm_pkg::bfm_sts_t                   sts,
    output bfm_pkg::bfm_result_t                result
);

    localparam int NB_W   = $clog2(MAX_BITS + 1);
    localparam int PRB_W  = $clog2(MAX_HASHES + 1);
    localparam int ROWS   = (MAX_BITS + bfm_pkg::ROW_BITS - 1) / bfm_pkg::ROW_BITS;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Configuration
    logic [bfm_pkg::NUM_BITS_W-1:0]   num_bits_reg;
    logic [bfm_pkg::NUM_HASHES_W-1:0] num_hashes_reg;
    logic [NB_W-1:0]                  nb;
    logic [PRB_W-1:0]                 nh;

    // Item state
    logic [bfm_pkg::ACTION_W-1:0] action_reg;
    logic [bfm_pkg::KEY_W-1:0]    key_reg;
    logic [PRB_W-1:0]             probe_reg;
    logic                         hit_reg;
    logic [bfm_pkg::COUNT_W-1:0]  count_reg;

    // Hash
    logic [bfm_pkg::KEY_W-1:0] h_reg;
    logic [bfm_pkg::KEY_W-1:0] mix_in;
    logic [bfm_pkg::KEY_W-1:0] mix_out;
    logic [bfm_pkg::KEY_W-1:0] lo_reg;
    logic [31:0]               hi_reg;
    logic [31:0]               mul_a;
    logic [31:0]               mul_b;
    logic [63:0]               mul_prod;
    logic [31:0]               sum_hi;

    // Remainder and store
    logic                   div_busy;
    logic [NB_W-1:0]        pos;
    logic [ROW_W-1:0]       pos_row;
    logic [bfm_pkg::ROW_BIT_W-1:0] pos_bit;
    logic [ROW_W-1:0]       sweep_reg;
    logic                   sweep_last;
    logic [bfm_pkg::ROW_BITS-1:0] mem [ROWS];
    logic [bfm_pkg::ROW_BITS-1:0] rd_data_reg;
    logic                   mem_we;
    logic [ROW_W-1:0]       mem_waddr;
    logic [bfm_pkg::ROW_BITS-1:0] mem_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_bits_reg   <= bfm_pkg::NUM_BITS_RESET;
            num_hashes_reg <= bfm_pkg::NUM_HASHES_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == bfm_pkg::REG_NUM_BITS)
            begin
                num_bits_reg <= cfg_data[bfm_pkg::NUM_BITS_W-1:0];
            end
            else if (cfg_index == bfm_pkg::REG_NUM_HASHES)
            begin
                num_hashes_reg <= cfg_data[bfm_pkg::NUM_HASHES_W-1:0];
            end
        end
    end

    // Clamp to the built store size and probe limit
    assign nb = (32'(num_bits_reg) > 32'(MAX_BITS)) ? NB_W'(MAX_BITS) : NB_W'(num_bits_reg);
    assign nh = (32'(num_hashes_reg) > 32'(MAX_HASHES)) ? PRB_W'(MAX_HASHES)
                                                         : PRB_W'(num_hashes_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            action_reg <= cmd.action;
            key_reg    <= cmd.key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
            hit_reg   <= 1'b0;
            count_reg <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            if (ctl.latch)
            begin
                probe_reg <= '0;
                hit_reg   <= (cmd.action == bfm_pkg::ACT_QUERY);
            end
            else if (ctl.probe_next)
            begin
                probe_reg <= probe_reg + 1'b1;
            end

            if (ctl.access && action_reg == bfm_pkg::ACT_QUERY && sts.miss)
            begin
                hit_reg <= 1'b0;
            end

            if (ctl.cnt_clr)
            begin
                count_reg <= '0;
            end
            else if (ctl.cnt_inc && count_reg != '1)
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (ctl.sweep)
            begin
                sweep_reg <= sweep_last ? '0 : sweep_reg + 1'b1;
            end
        end
    end

    // Hash: one shared 32x32 multiplier, 64x32 product taken in two halves
    assign mix_in   = key_reg ^ bfm_pkg::KEY_W'(probe_reg);
    assign mix_out  = h_reg ^ (h_reg >> bfm_pkg::MIX_SHIFT_A);
    assign mul_a    = (ctl.hop == bfm_pkg::HOP_MUL_HI) ? h_reg[63:32] : h_reg[31:0];
    assign mul_b    = ctl.mul_sel ? bfm_pkg::MIX_MUL2 : bfm_pkg::MIX_MUL1;
    assign mul_prod = mul_a * mul_b;
    assign sum_hi   = lo_reg[63:32] + hi_reg;

    always_ff @(posedge clk)
    begin
        unique case (ctl.hop)
            bfm_pkg::HOP_NONE:    ;
            bfm_pkg::HOP_LOAD:    h_reg  <= mix_in ^ (mix_in >> bfm_pkg::MIX_SHIFT_A);
            bfm_pkg::HOP_MUL_LO:  lo_reg <= mul_prod;
            bfm_pkg::HOP_MUL_HI:  hi_reg <= mul_prod[31:0];
            bfm_pkg::HOP_MUL_SUM: h_reg  <= {sum_hi, lo_reg[31:0]};
            bfm_pkg::HOP_MIX13:   h_reg  <= h_reg ^ (h_reg >> bfm_pkg::MIX_SHIFT_B);
        endcase
    end

    bfm_divider #(
        .DIV_W (NB_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctl.div_start),
        .dividend  (mix_out),
        .divisor   (nb),
        .busy      (div_busy),
        .remainder (pos)
    );

    assign pos_row    = ROW_W'(pos >> bfm_pkg::ROW_BIT_W);
    assign pos_bit    = pos[bfm_pkg::ROW_BIT_W-1:0];
    assign sweep_last = (sweep_reg == ROW_W'(ROWS - 1));

    // Bit store: one write port, one registered read port
    assign mem_we    = ctl.sweep || (ctl.access && action_reg == bfm_pkg::ACT_ADD);
    assign mem_waddr = ctl.sweep ? sweep_reg : pos_row;
    assign mem_wdata = ctl.sweep ? '0
                                 : (rd_data_reg | (bfm_pkg::ROW_BITS'(1) << pos_bit));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (ctl.mem_read)
        begin
            rd_data_reg <= mem[pos_row];
        end
    end

    always_comb
    begin
        sts.action     = action_reg;
        sts.no_probe   = (nb == '0) || (nh == '0);
        sts.last_probe = (PRB_W'(probe_reg + 1'b1) == nh);
        sts.miss       = !rd_data_reg[pos_bit];
        sts.div_busy   = div_busy;
        sts.sweep_last = sweep_last;
    end

    assign result.might_contain = hit_reg;
    assign result.element_count = count_reg;

endmodule

`default_nettype wire

/* sv/bfm_ctrl.sv */
// Controller state machine sequencing probes, store sweeps and result strobe.
`default_nettype none

module bfm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire bfm_pkg::bfm_sts_t sts,
    output bfm_pkg::bfm_ctl_t      ctl,
    output logic                   busy,
    output logic                   done
);

    bfm_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfm_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.hop    = bfm_pkg::HOP_NONE;
        busy       = 1'b1;
        done       = 1'b0;

        unique case (state_reg)
            bfm_pkg::ST_INIT:
            begin
                ctl.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = bfm_pkg::ST_IDLE;
                end
            end
            bfm_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctl.latch  = 1'b1;
                    state_next = bfm_pkg::ST_DECODE;
                end
            end
            bfm_pkg::ST_DECODE:
            begin
                unique case (sts.action)
                    bfm_pkg::ACT_ADD:
                    begin
                        if (sts.no_probe)
                        begin
                            ctl.cnt_inc = 1'b1;
                            state_next  = bfm_pkg::ST_FINISH;
                        end
                        else
                        begin
                            state_next = bfm_pkg::ST_LOAD;
                        end
                    end
                    bfm_pkg::ACT_QUERY:
                    begin
                        state_next = sts.no_probe ? bfm_pkg::ST_FINISH : bfm_pkg::ST_LOAD;
                    end
                    bfm_pkg::ACT_CLEAR:
                    begin
                        ctl.cnt_clr = 1'b1;
                        state_next  = bfm_pkg::ST_WIPE;
                    end
                    default:
                    begin
                        state_next = bfm_pkg::ST_FINISH;
                    end
                endcase
            end
            bfm_pkg::ST_LOAD:
            begin
                ctl.hop    = bfm_pkg::HOP_LOAD;
                state_next = bfm_pkg::ST_MUL1_LO;
            end
            bfm_pkg::ST_MUL1_LO:
            begin
                ctl.hop    = bfm_pkg::HOP_MUL_LO;
                state_next = bfm_pkg::ST_MUL1_HI;
            end
            bfm_pkg::ST_MUL1_HI:
            begin
                ctl.hop    = bfm_pkg::HOP_MUL_HI;
                state_next = bfm_pkg::ST_MUL1_SUM;
            end
            bfm_pkg::ST_MUL1_SUM:
            begin
                ctl.hop    = bfm_pkg::HOP_MUL_SUM;
                state_next = bfm_pkg::ST_MIX13;
            end
            bfm_pkg::ST_MIX13:
            begin
                ctl.hop    = bfm_pkg::HOP_MIX13;
                state_next = bfm_pkg::ST_MUL2_LO;
            end
            bfm_pkg::ST_MUL2_LO:
            begin
                ctl.hop     = bfm_pkg::HOP_MUL_LO;
                ctl.mul_sel = 1'b1;
                state_next  = bfm_pkg::ST_MUL2_HI;
            end
            bfm_pkg::ST_MUL2_HI:
            begin
                ctl.hop     = bfm_pkg::HOP_MUL_HI;
                ctl.mul_sel = 1'b1;
                state_next  = bfm_pkg::ST_MUL2_SUM;
            end
            bfm_pkg::ST_MUL2_SUM:
            begin
                ctl.hop    = bfm_pkg::HOP_MUL_SUM;
                state_next = bfm_pkg::ST_MIX16;
            end
            bfm_pkg::ST_MIX16:
            begin
                // final mix feeds the remainder unit directly
                ctl.div_start = 1'b1;
                state_next    = bfm_pkg::ST_DIV_WAIT;
            end
            bfm_pkg::ST_DIV_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    state_next = bfm_pkg::ST_READ;
                end
            end
            bfm_pkg::ST_READ:
            begin
                ctl.mem_read = 1'b1;
                state_next   = bfm_pkg::ST_ACCESS;
            end
            bfm_pkg::ST_ACCESS:
            begin
                ctl.access = 1'b1;
                if (sts.action == bfm_pkg::ACT_ADD)
                begin
                    if (sts.last_probe)
                    begin
                        ctl.cnt_inc = 1'b1;
                        state_next  = bfm_pkg::ST_FINISH;
                    end
                    else
                    begin
                        ctl.probe_next = 1'b1;
                        state_next     = bfm_pkg::ST_LOAD;
                    end
                end
                else if (sts.miss || sts.last_probe)
                begin
                    state_next = bfm_pkg::ST_FINISH;
                end
                else
                begin
                    ctl.probe_next = 1'b1;
                    state_next     = bfm_pkg::ST_LOAD;
                end
            end
            bfm_pkg::ST_WIPE:
            begin
                ctl.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = bfm_pkg::ST_FINISH;
                end
            end
            bfm_pkg::ST_FINISH:
            begin
                done       = 1'b1;
                state_next = bfm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bfm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/bloom_filter_membership.sv */
// Top level of the Bloom filter membership block: controller plus datapath.
`default_nettype none

// An add or query runs its probes one at a time (a query stops at its first clear
// bit); each probe is hashed, reduced by the remainder unit, then its store row is
// read and, for an add, updated. Zero probes finish without a store access. The
// next start is taken the cycle after done; a clear sweeps all ROWS store rows.
// Reset: busy stays high during a clearing pass over ROWS = ceil(MAX_BITS/64) rows.
// Results are strobed for one cycle with done; the receiver cannot stall them.
module bloom_filter_membership #(
    parameter int MAX_BITS   = bfm_pkg::MAX_BITS_DEFAULT,
    parameter int MAX_HASHES = bfm_pkg::MAX_HASHES_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // command transaction: taken when start is high and busy is low
    input  wire logic                            start,
    output logic                                 busy,
    input  wire bfm_pkg::bfm_cmd_t               cmd,
    // result transaction: valid for the single cycle done is high
    output logic                                 done,
    output bfm_pkg::bfm_result_t                 result,
    // register write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [bfm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bfm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    bfm_pkg::bfm_ctl_t ctl;
    bfm_pkg::bfm_sts_t sts;

    // Take register writes only while no command transaction is in flight or being
    // taken, so an item always runs with one fixed sizing.
    assign cfg_ready = !busy && !start;

    // Controller: walks each item through hash, remainder and store access,
    // one probe at a time, and runs the row sweep on reset and on clear.
    bfm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    // Datapath: config registers, mixer, remainder unit, 64-bit-row bit store,
    // saturating element count and the answer register.
    bfm_datapath #(
        .MAX_BITS   (MAX_BITS),
        .MAX_HASHES (MAX_HASHES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .sts       (sts),
        .result    (result)
    );

endmodule

`default_nettype wire
